// ===== rtl/qrp_pkg.sv =====
// Shared widths, stage counts and saturation limits for the quaternion point rotator.
package qrp_pkg;

   // Field widths
   localparam int QUAT_W  = 16;
   localparam int POINT_W = 24;
   localparam int OUT_W   = 24;

   // Internal datapath widths
   localparam int PROD1_W = QUAT_W + POINT_W;   // q component times point coordinate
   localparam int T_W     = PROD1_W + 2;        // sum of three such products
   localparam int SQ_W    = 2 * QUAT_W - 1;     // one squared component
   localparam int N_W     = SQ_W + 2;           // sum of four squares
   localparam int PROD2_W = T_W + QUAT_W;       // t term times q component
   localparam int F_W     = PROD2_W + 2;        // sum of four such products
   localparam int S_W     = 31;                 // floor(sqrt(N * 2^28))
   localparam int SQ_REM_W = S_W + 3;           // remainder of the root recurrence
   localparam int VAL_W   = 2 * S_W;            // radicand padded to whole digit pairs
   localparam int VAL_SH  = 28;                 // radicand is N shifted left by this

   // Stage counts
   localparam int FRONT_STG = 4;                // products, sums, products, sums
   localparam int SQRT_STG  = S_W;              // one root bit per stage
   localparam int F_DLY     = 2 + SQRT_STG - FRONT_STG;
   localparam int DIV_STG   = OUT_W - 1;        // quotient bits below the saturation point
   localparam int PIPE_STG  = 2 + SQRT_STG + 1 + DIV_STG + 1;

   // Bus widths
   localparam int REQ_W = 4 * QUAT_W + 3 * POINT_W;
   localparam int RSP_W = 3 * OUT_W;

   // Saturation limits
   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

// ===== rtl/qrp_front.sv =====
// Product pipeline: q*p, then the vector part of (q*p) times conj(q), plus the squared norm.
module qrp_front (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [qrp_pkg::QUAT_W-1:0]    quat_w,
   input  logic signed [qrp_pkg::QUAT_W-1:0]    quat_x,
   input  logic signed [qrp_pkg::QUAT_W-1:0]    quat_y,
   input  logic signed [qrp_pkg::QUAT_W-1:0]    quat_z,
   input  logic signed [qrp_pkg::POINT_W-1:0]   point_x,
   input  logic signed [qrp_pkg::POINT_W-1:0]   point_y,
   input  logic signed [qrp_pkg::POINT_W-1:0]   point_z,
   output logic        [qrp_pkg::N_W-1:0]       n_sum,
   output logic signed [qrp_pkg::F_W-1:0]       f_x,
   output logic signed [qrp_pkg::F_W-1:0]       f_y,
   output logic signed [qrp_pkg::F_W-1:0]       f_z
);

   logic signed [qrp_pkg::QUAT_W-1:0]  qv [4];
   logic signed [qrp_pkg::POINT_W-1:0] pv [3];

   logic signed [qrp_pkg::PROD1_W-1:0] pr_in [4][3];
   logic signed [qrp_pkg::PROD1_W-1:0] pr_ff [4][3];
   logic        [qrp_pkg::SQ_W-1:0]    sq_in [4];
   logic        [qrp_pkg::SQ_W-1:0]    sq_ff [4];
   logic signed [qrp_pkg::QUAT_W-1:0]  q1_ff [4];

   logic signed [qrp_pkg::T_W-1:0]     t_in [4];
   logic signed [qrp_pkg::T_W-1:0]     t_ff [4];
   logic        [qrp_pkg::N_W-1:0]     n_in;
   logic        [qrp_pkg::N_W-1:0]     n_ff;
   logic signed [qrp_pkg::QUAT_W-1:0]  q2_ff [4];

   logic signed [qrp_pkg::PROD2_W-1:0] m_in [3][4];
   logic signed [qrp_pkg::PROD2_W-1:0] m_ff [3][4];

   logic signed [qrp_pkg::F_W-1:0]     f_in [3];
   logic signed [qrp_pkg::F_W-1:0]     f_ff [3];
   logic signed [qrp_pkg::F_W-1:0]     fd_ff [qrp_pkg::F_DLY][3];

   assign qv[0] = quat_w;
   assign qv[1] = quat_x;
   assign qv[2] = quat_y;
   assign qv[3] = quat_z;
   assign pv[0] = point_x;
   assign pv[1] = point_y;
   assign pv[2] = point_z;

   // Stage 1: component by coordinate products and squares
   always_comb begin
      for (int qi = 0; qi < 4; qi++) begin
         for (int pi = 0; pi < 3; pi++) begin
            pr_in[qi][pi] = qrp_pkg::PROD1_W'(qv[qi]) * qrp_pkg::PROD1_W'(pv[pi]);
         end
         sq_in[qi] = qrp_pkg::SQ_W'((2*qrp_pkg::QUAT_W)'(qv[qi]) *
                                    (2*qrp_pkg::QUAT_W)'(qv[qi]));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pr_ff <= pr_in;
         sq_ff <= sq_in;
         q1_ff <= qv;
      end
   end

   // Stage 2: q * p as a quaternion, and the squared norm
   always_comb begin
      t_in[0] = -qrp_pkg::T_W'(pr_ff[1][0]) - qrp_pkg::T_W'(pr_ff[2][1])
                - qrp_pkg::T_W'(pr_ff[3][2]);
      t_in[1] =  qrp_pkg::T_W'(pr_ff[0][0]) + qrp_pkg::T_W'(pr_ff[2][2])
                - qrp_pkg::T_W'(pr_ff[3][1]);
      t_in[2] =  qrp_pkg::T_W'(pr_ff[0][1]) + qrp_pkg::T_W'(pr_ff[3][0])
                - qrp_pkg::T_W'(pr_ff[1][2]);
      t_in[3] =  qrp_pkg::T_W'(pr_ff[0][2]) + qrp_pkg::T_W'(pr_ff[1][1])
                - qrp_pkg::T_W'(pr_ff[2][0]);
      n_in = qrp_pkg::N_W'(sq_ff[0]) + qrp_pkg::N_W'(sq_ff[1])
           + qrp_pkg::N_W'(sq_ff[2]) + qrp_pkg::N_W'(sq_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff  <= t_in;
         n_ff  <= n_in;
         q2_ff <= q1_ff;
      end
   end

   // Stage 3: products with the conjugate; signs of conj(q) folded into stage 4
   always_comb begin
      m_in[0][0] = qrp_pkg::PROD2_W'(t_ff[1]) * qrp_pkg::PROD2_W'(q2_ff[0]);
      m_in[0][1] = qrp_pkg::PROD2_W'(t_ff[0]) * qrp_pkg::PROD2_W'(q2_ff[1]);
      m_in[0][2] = qrp_pkg::PROD2_W'(t_ff[2]) * qrp_pkg::PROD2_W'(q2_ff[3]);
      m_in[0][3] = qrp_pkg::PROD2_W'(t_ff[3]) * qrp_pkg::PROD2_W'(q2_ff[2]);
      m_in[1][0] = qrp_pkg::PROD2_W'(t_ff[2]) * qrp_pkg::PROD2_W'(q2_ff[0]);
      m_in[1][1] = qrp_pkg::PROD2_W'(t_ff[0]) * qrp_pkg::PROD2_W'(q2_ff[2]);
      m_in[1][2] = qrp_pkg::PROD2_W'(t_ff[3]) * qrp_pkg::PROD2_W'(q2_ff[1]);
      m_in[1][3] = qrp_pkg::PROD2_W'(t_ff[1]) * qrp_pkg::PROD2_W'(q2_ff[3]);
      m_in[2][0] = qrp_pkg::PROD2_W'(t_ff[3]) * qrp_pkg::PROD2_W'(q2_ff[0]);
      m_in[2][1] = qrp_pkg::PROD2_W'(t_ff[0]) * qrp_pkg::PROD2_W'(q2_ff[3]);
      m_in[2][2] = qrp_pkg::PROD2_W'(t_ff[1]) * qrp_pkg::PROD2_W'(q2_ff[2]);
      m_in[2][3] = qrp_pkg::PROD2_W'(t_ff[2]) * qrp_pkg::PROD2_W'(q2_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff <= m_in;
      end
   end

   // Stage 4: vector part, pattern + - - + on each row
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         f_in[r] = qrp_pkg::F_W'(m_ff[r][0]) - qrp_pkg::F_W'(m_ff[r][1])
                 - qrp_pkg::F_W'(m_ff[r][2]) + qrp_pkg::F_W'(m_ff[r][3]);
      end
   end

   // Hold the vector part until the root is ready
   always_ff @(posedge clock) begin
      if (en) begin
         f_ff     <= f_in;
         fd_ff[0] <= f_ff;
         for (int k = 1; k < qrp_pkg::F_DLY; k++) begin
            fd_ff[k] <= fd_ff[k-1];
         end
      end
   end

   assign n_sum = n_ff;
   assign f_x   = fd_ff[qrp_pkg::F_DLY-1][0];
   assign f_y   = fd_ff[qrp_pkg::F_DLY-1][1];
   assign f_z   = fd_ff[qrp_pkg::F_DLY-1][2];

endmodule

// ===== rtl/qrp_sqrt.sv =====
// Pipelined integer square root of N * 2^28, one root bit per stage.
module qrp_sqrt (
   input  logic                        clock,
   input  logic                        en,
   input  logic [qrp_pkg::N_W-1:0]     n_in,
   output logic [qrp_pkg::S_W-1:0]     s_out
);

   logic [qrp_pkg::S_W-1:0]      rt_ff [qrp_pkg::SQRT_STG];
   logic [qrp_pkg::S_W-1:0]      rt_in [qrp_pkg::SQRT_STG];
   logic [qrp_pkg::SQ_REM_W-1:0] rm_ff [qrp_pkg::SQRT_STG];
   logic [qrp_pkg::SQ_REM_W-1:0] rm_in [qrp_pkg::SQRT_STG];
   logic [qrp_pkg::N_W-1:0]      nv_ff [qrp_pkg::SQRT_STG];
   logic [qrp_pkg::N_W-1:0]      nv_in [qrp_pkg::SQRT_STG];

   logic [qrp_pkg::S_W-1:0]      rt_prev [qrp_pkg::SQRT_STG];
   logic [qrp_pkg::SQ_REM_W-1:0] rm_prev [qrp_pkg::SQRT_STG];
   logic [qrp_pkg::VAL_W-1:0]    val     [qrp_pkg::SQRT_STG];
   logic [qrp_pkg::SQ_REM_W-1:0] rm_sh   [qrp_pkg::SQRT_STG];
   logic [qrp_pkg::SQ_REM_W-1:0] test    [qrp_pkg::SQRT_STG];

   // Each stage brings down one digit pair and tries root bit one
   always_comb begin
      for (int k = 0; k < qrp_pkg::SQRT_STG; k++) begin
         if (k == 0) begin
            rt_prev[k] = '0;
            rm_prev[k] = '0;
            nv_in[k]   = n_in;
         end else begin
            rt_prev[k] = rt_ff[k-1];
            rm_prev[k] = rm_ff[k-1];
            nv_in[k]   = nv_ff[k-1];
         end
         val[k]   = qrp_pkg::VAL_W'({nv_in[k], {qrp_pkg::VAL_SH{1'b0}}});
         rm_sh[k] = {rm_prev[k][qrp_pkg::SQ_REM_W-3:0],
                     val[k][qrp_pkg::VAL_W-1-2*k -: 2]};
         test[k]  = {1'b0, rt_prev[k], 2'b01};
         if (rm_sh[k] >= test[k]) begin
            rm_in[k] = rm_sh[k] - test[k];
            rt_in[k] = {rt_prev[k][qrp_pkg::S_W-2:0], 1'b1};
         end else begin
            rm_in[k] = rm_sh[k];
            rt_in[k] = {rt_prev[k][qrp_pkg::S_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rt_ff <= rt_in;
         rm_ff <= rm_in;
         nv_ff <= nv_in;
      end
   end

   assign s_out = rt_ff[qrp_pkg::SQRT_STG-1];

endmodule

// ===== rtl/qrp_div_lane.sv =====
// One output lane: rounded division of the vector part by the root, with saturation.
module qrp_div_lane (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [qrp_pkg::F_W-1:0]     f_in,
   input  logic        [qrp_pkg::S_W-1:0]     s_in,
   output logic signed [qrp_pkg::OUT_W-1:0]   res
);

   logic [qrp_pkg::F_W-1:0]     mag;
   logic [qrp_pkg::F_W-1:0]     dvd;
   logic [qrp_pkg::F_W-1:0]     sat_lim;

   logic [qrp_pkg::F_W-1:0]     rem0_ff;
   logic [qrp_pkg::S_W-1:0]     s0_ff;
   logic                        neg0_ff;
   logic                        sat0_ff;
   logic                        zero0_ff;

   logic [qrp_pkg::F_W-1:0]     rem_ff  [qrp_pkg::DIV_STG];
   logic [qrp_pkg::F_W-1:0]     rem_in  [qrp_pkg::DIV_STG];
   logic [qrp_pkg::DIV_STG-1:0] quo_ff  [qrp_pkg::DIV_STG];
   logic [qrp_pkg::DIV_STG-1:0] quo_in  [qrp_pkg::DIV_STG];
   logic [qrp_pkg::S_W-1:0]     s_ff    [qrp_pkg::DIV_STG];
   logic [qrp_pkg::S_W-1:0]     s_in_a  [qrp_pkg::DIV_STG];
   logic                        neg_ff  [qrp_pkg::DIV_STG];
   logic                        neg_in  [qrp_pkg::DIV_STG];
   logic                        sat_ff  [qrp_pkg::DIV_STG];
   logic                        sat_in  [qrp_pkg::DIV_STG];
   logic                        zero_ff [qrp_pkg::DIV_STG];
   logic                        zero_in [qrp_pkg::DIV_STG];

   logic [qrp_pkg::F_W-1:0]     rem_prev [qrp_pkg::DIV_STG];
   logic [qrp_pkg::DIV_STG-1:0] quo_prev [qrp_pkg::DIV_STG];
   logic [qrp_pkg::F_W-1:0]     trial    [qrp_pkg::DIV_STG];

   logic signed [qrp_pkg::OUT_W-1:0] res_in;
   logic signed [qrp_pkg::OUT_W-1:0] res_ff;

   // Prepare: magnitude plus half the divisor, and the saturation test
   always_comb begin
      mag     = f_in[qrp_pkg::F_W-1] ? qrp_pkg::F_W'(-f_in) : qrp_pkg::F_W'(f_in);
      dvd     = mag + qrp_pkg::F_W'(s_in >> 1);
      sat_lim = qrp_pkg::F_W'({s_in, {qrp_pkg::DIV_STG{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem0_ff  <= dvd;
         s0_ff    <= s_in;
         neg0_ff  <= f_in[qrp_pkg::F_W-1];
         sat0_ff  <= (dvd >= sat_lim);
         zero0_ff <= (s_in == '0);
      end
   end

   // Restoring division, most significant quotient bit first
   always_comb begin
      for (int k = 0; k < qrp_pkg::DIV_STG; k++) begin
         if (k == 0) begin
            rem_prev[k] = rem0_ff;
            quo_prev[k] = '0;
            s_in_a[k]   = s0_ff;
            neg_in[k]   = neg0_ff;
            sat_in[k]   = sat0_ff;
            zero_in[k]  = zero0_ff;
         end else begin
            rem_prev[k] = rem_ff[k-1];
            quo_prev[k] = quo_ff[k-1];
            s_in_a[k]   = s_ff[k-1];
            neg_in[k]   = neg_ff[k-1];
            sat_in[k]   = sat_ff[k-1];
            zero_in[k]  = zero_ff[k-1];
         end
         trial[k]  = qrp_pkg::F_W'(s_in_a[k]) << (qrp_pkg::DIV_STG - 1 - k);
         quo_in[k] = quo_prev[k];
         if (rem_prev[k] >= trial[k]) begin
            rem_in[k] = rem_prev[k] - trial[k];
            quo_in[k][qrp_pkg::DIV_STG - 1 - k] = 1'b1;
         end else begin
            rem_in[k] = rem_prev[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         s_ff    <= s_in_a;
         neg_ff  <= neg_in;
         sat_ff  <= sat_in;
         zero_ff <= zero_in;
      end
   end

   // Apply sign, saturation and the zero-magnitude case
   always_comb begin
      if (zero_ff[qrp_pkg::DIV_STG-1]) begin
         res_in = '0;
      end else if (sat_ff[qrp_pkg::DIV_STG-1]) begin
         res_in = neg_ff[qrp_pkg::DIV_STG-1] ? qrp_pkg::OUT_MIN : qrp_pkg::OUT_MAX;
      end else if (neg_ff[qrp_pkg::DIV_STG-1]) begin
         res_in = -$signed({1'b0, quo_ff[qrp_pkg::DIV_STG-1]});
      end else begin
         res_in = $signed({1'b0, quo_ff[qrp_pkg::DIV_STG-1]});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// ===== rtl/quaternion_rotate_point_top.sv =====
// Quaternion point rotator: rotates one 3-D point by (q p conj(q)) / (|q| * 2^14) per transfer.
//
// Takes one point per clock while req_tready is high and returns one rotated point
// per point, in order, from its output register. The
// depth is set by the 31-stage square root of the quaternion norm, one root bit
// per stage, followed by a 23-stage divider per axis, one quotient bit per stage.
// The whole pipeline advances together; a one-entry skid buffer behind the output
// register absorbs a stall, and req_tready falls only while that buffer is full.
// Results are rounded to nearest, ties away from zero, and saturated to 24 bits;
// an all-zero quaternion gives a zero point.
module quaternion_rotate_point_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48],
   // point_x[87:64], point_y[111:88], point_z[135:112]
   input  logic [qrp_pkg::REQ_W-1:0]       req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // rotated_x[23:0], rotated_y[47:24], rotated_z[71:48]
   output logic [qrp_pkg::RSP_W-1:0]       rsp_tdata
);

   logic                            pipe_en;
   logic [qrp_pkg::PIPE_STG-1:0]    vld_ff;
   logic [qrp_pkg::PIPE_STG-1:0]    vld_in;

   logic [qrp_pkg::N_W-1:0]         n_sum;
   logic [qrp_pkg::S_W-1:0]         s_val;
   logic signed [qrp_pkg::F_W-1:0]  f_x;
   logic signed [qrp_pkg::F_W-1:0]  f_y;
   logic signed [qrp_pkg::F_W-1:0]  f_z;
   logic signed [qrp_pkg::OUT_W-1:0] res_x;
   logic signed [qrp_pkg::OUT_W-1:0] res_y;
   logic signed [qrp_pkg::OUT_W-1:0] res_z;
   logic [qrp_pkg::RSP_W-1:0]       pipe_data;

   logic                            rsp_vld_ff;
   logic                            rsp_vld_in;
   logic [qrp_pkg::RSP_W-1:0]       rsp_data_ff;
   logic [qrp_pkg::RSP_W-1:0]       rsp_data_in;
   logic                            skid_vld_ff;
   logic                            skid_vld_in;
   logic [qrp_pkg::RSP_W-1:0]       skid_data_ff;
   logic [qrp_pkg::RSP_W-1:0]       skid_data_in;
   logic                            out_free;

   // Advance the pipeline whenever the skid buffer is empty
   assign pipe_en    = !skid_vld_ff;
   assign req_tready = pipe_en;

   qrp_front u_front (
      .clock   (clock),
      .en      (pipe_en),
      .quat_w  (req_tdata[15:0]),
      .quat_x  (req_tdata[31:16]),
      .quat_y  (req_tdata[47:32]),
      .quat_z  (req_tdata[63:48]),
      .point_x (req_tdata[87:64]),
      .point_y (req_tdata[111:88]),
      .point_z (req_tdata[135:112]),
      .n_sum   (n_sum),
      .f_x     (f_x),
      .f_y     (f_y),
      .f_z     (f_z)
   );

   qrp_sqrt u_sqrt (
      .clock (clock),
      .en    (pipe_en),
      .n_in  (n_sum),
      .s_out (s_val)
   );

   qrp_div_lane u_lane_x (
      .clock (clock),
      .en    (pipe_en),
      .f_in  (f_x),
      .s_in  (s_val),
      .res   (res_x)
   );

   qrp_div_lane u_lane_y (
      .clock (clock),
      .en    (pipe_en),
      .f_in  (f_y),
      .s_in  (s_val),
      .res   (res_y)
   );

   qrp_div_lane u_lane_z (
      .clock (clock),
      .en    (pipe_en),
      .f_in  (f_z),
      .s_in  (s_val),
      .res   (res_z)
   );

   assign pipe_data = {res_z, res_y, res_x};

   // Shift valid bits alongside the data
   always_comb begin
      vld_in = {vld_ff[qrp_pkg::PIPE_STG-2:0], req_tvalid};
   end

   // Load the output register, or park the item in the skid buffer
   always_comb begin
      out_free     = !rsp_vld_ff || rsp_tready;
      rsp_vld_in   = rsp_vld_ff;
      rsp_data_in  = rsp_data_ff;
      skid_vld_in  = skid_vld_ff;
      skid_data_in = skid_data_ff;
      if (out_free) begin
         if (skid_vld_ff) begin
            rsp_vld_in  = 1'b1;
            rsp_data_in = skid_data_ff;
            skid_vld_in = 1'b0;
         end else if (pipe_en && vld_ff[qrp_pkg::PIPE_STG-1]) begin
            rsp_vld_in  = 1'b1;
            rsp_data_in = pipe_data;
         end else begin
            rsp_vld_in  = 1'b0;
         end
      end else if (pipe_en && vld_ff[qrp_pkg::PIPE_STG-1]) begin
         skid_vld_in  = 1'b1;
         skid_data_in = pipe_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (pipe_en) begin
            vld_ff <= vld_in;
         end
         rsp_vld_ff  <= rsp_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The skid buffer fills only behind a waiting result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> rsp_vld_ff)
      else $error("skid buffer holds an item while the output register is empty");

   // A stalled pipeline keeps its valid bits
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(vld_ff))
      else $error("pipeline valid bits moved during a stall");

   // Draining the skid buffer refills the output register
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_vld_ff && rsp_tready) |=> (rsp_vld_ff && !skid_vld_ff))
      else $error("skid buffer drain lost an item");

endmodule
